[design/afrc_pkg.sv]
`default_nettype none

package afrc_pkg;

    localparam logic [7:0]  CRC_POLY       = 8'h31;
    localparam logic [7:0]  CRC_INIT       = 8'hFF;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
    localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;

    localparam logic [7:0]  ADDR_RESET     = 8'd1;
    localparam logic [15:0] GAP_RESET      = 16'd35;
    localparam logic [15:0] BREAK_RESET    = 16'd1000;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_GAP_TICKS      = 2'd1;
    localparam logic [1:0] REG_BREAK_TICKS    = 2'd2;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_CRC_OK  = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;
    localparam logic [1:0] ST_ABORT   = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [8:0] byte_index;
        logic       last;
        logic [1:0] status;
    } t_result;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/afrc_in_reg.sv]
`default_nettype none

module afrc_in_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  afrc_pkg::t_item      i_item,
    output logic                 o_valid,
    input  wire                  i_take,
    output afrc_pkg::t_item      o_item
);

    logic            r_valid;
    afrc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/afrc_core.sv]
`default_nettype none

module afrc_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [15:0]          i_cfg_data,
    input  wire                  i_fire,
    input  afrc_pkg::t_item      i_item,
    output logic                 o_res_valid,
    output afrc_pkg::t_result    o_res
);

    logic [7:0]  r_dev_addr;
    logic [15:0] r_gap_ticks;
    logic [15:0] r_break_ticks;

    logic        r_gap_seen,  n_gap_seen;
    logic        r_in_frame,  n_in_frame;
    logic [8:0]  r_byte_cnt,  n_byte_cnt;
    logic [8:0]  r_exp_cnt,   n_exp_cnt;
    logic [7:0]  r_crc,       n_crc;
    logic [15:0] r_silence,   n_silence;

    logic [7:0]  b;
    logic [7:0]  crc_next;
    logic [15:0] sil_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= afrc_pkg::ADDR_RESET;
            r_gap_ticks   <= afrc_pkg::GAP_RESET;
            r_break_ticks <= afrc_pkg::BREAK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afrc_pkg::REG_DEVICE_ADDRESS: r_dev_addr    <= i_cfg_data[7:0];
                afrc_pkg::REG_GAP_TICKS:      r_gap_ticks   <= i_cfg_data;
                afrc_pkg::REG_BREAK_TICKS:    r_break_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign b        = i_item.rx_byte;
    assign crc_next = afrc_pkg::crc8_update(r_in_frame ? r_crc : afrc_pkg::CRC_INIT, b);
    assign sil_inc  = (r_silence == afrc_pkg::SILENCE_MAX) ? r_silence : r_silence + 16'd1;

    always_comb begin
        n_gap_seen  = r_gap_seen;
        n_in_frame  = r_in_frame;
        n_byte_cnt  = r_byte_cnt;
        n_exp_cnt   = r_exp_cnt;
        n_crc       = r_crc;
        n_silence   = r_silence;
        o_res_valid = 1'b0;
        o_res       = '{frame_byte: b, byte_index: r_byte_cnt, last: 1'b0,
                        status: afrc_pkg::ST_BUSY};

        if (i_item.opcode == afrc_pkg::OP_TICK) begin
            n_silence = sil_inc;
            if (!r_in_frame) begin
                if (sil_inc >= r_gap_ticks) begin
                    n_gap_seen = 1'b1;
                end
            end else if (sil_inc >= r_break_ticks) begin
                o_res_valid = 1'b1;
                o_res       = '{frame_byte: 8'd0, byte_index: r_byte_cnt, last: 1'b1,
                                status: afrc_pkg::ST_ABORT};
                n_in_frame  = 1'b0;
                n_byte_cnt  = '0;
                n_exp_cnt   = '0;
                n_crc       = afrc_pkg::CRC_INIT;
                n_gap_seen  = (sil_inc >= r_gap_ticks);
            end
        end else begin
            n_silence = '0;
            if (!r_in_frame) begin
                if (r_gap_seen && b == r_dev_addr) begin
                    n_gap_seen  = 1'b0;
                    n_in_frame  = 1'b1;
                    n_byte_cnt  = 9'd1;
                    n_exp_cnt   = '0;
                    n_crc       = crc_next;
                    o_res_valid = 1'b1;
                    o_res.byte_index = '0;
                end else if (b != 8'd0) begin
                    n_gap_seen = 1'b0;
                end
            end else begin
                n_gap_seen  = 1'b0;
                o_res_valid = 1'b1;
                if (r_byte_cnt == 9'd3) begin
                    n_exp_cnt = {1'b0, b} + afrc_pkg::FRAME_OVERHEAD;
                end
                if (r_byte_cnt >= 9'd4 && r_byte_cnt + 9'd1 == r_exp_cnt) begin
                    o_res.last   = 1'b1;
                    o_res.status = (b == r_crc) ? afrc_pkg::ST_CRC_OK : afrc_pkg::ST_CRC_ERR;
                    n_in_frame   = 1'b0;
                    n_byte_cnt   = '0;
                    n_exp_cnt    = '0;
                    n_crc        = afrc_pkg::CRC_INIT;
                end else begin
                    n_crc      = crc_next;
                    n_byte_cnt = r_byte_cnt + 9'd1;
                end
            end
        end

        if (!i_fire) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_seen <= 1'b0;
            r_in_frame <= 1'b0;
            r_byte_cnt <= '0;
            r_exp_cnt  <= '0;
            r_crc      <= afrc_pkg::CRC_INIT;
            r_silence  <= '0;
        end else if (i_fire) begin
            r_gap_seen <= n_gap_seen;
            r_in_frame <= n_in_frame;
            r_byte_cnt <= n_byte_cnt;
            r_exp_cnt  <= n_exp_cnt;
            r_crc      <= n_crc;
            r_silence  <= n_silence;
        end
    end

endmodule

`default_nettype wire

[design/afrc_out_reg.sv]
`default_nettype none

module afrc_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  afrc_pkg::t_result    i_res,
    output logic                 o_valid,
    input  wire                  i_ready,
    output afrc_pkg::t_result    o_res
);

    logic              r_valid;
    afrc_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[design/addressed_frame_receiver_crc8.sv]
// addressed frame receiver with crc-8 check
//
// slave stream: one transfer per received byte or time tick; tuser = 0 marks a
// byte in tdata, tuser = 1 marks one tick of line silence (tdata ignored).
// master stream: one transfer per accepted frame byte or abort report; tdata
// carries the byte and its index in the frame, tuser the status (in progress,
// crc ok, crc error, aborted), tlast marks the final byte or an abort.
// config port: write enable, index (0 address, 1 gap ticks, 2 break ticks) and
// data; writes take effect on the next cycle and are meant for idle periods.
//
// throughput is one transfer per cycle while the master side accepts; each item
// goes through an input register, the state update and crc step, and an output
// register, from which the master side takes its result.
// reset (synchronous, active low) clears the frame state, silence count and
// both stage registers, and loads the register defaults. when the master side
// stalls the output register holds its result and the input side keeps
// taking transfers until both stage registers are full.
`default_nettype none

module addressed_frame_receiver_crc8 (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // rx_byte
    input  wire         i_s_tuser,   // opcode
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // frame_byte [7:0], byte_index [16:8], zero fill
    output logic        o_m_tlast,   // last
    output logic [1:0]  o_m_tuser,   // status
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    afrc_pkg::t_item   s_item;
    afrc_pkg::t_item   core_item;
    afrc_pkg::t_result core_res;
    afrc_pkg::t_result out_res;
    logic              core_valid;
    logic              core_fire;
    logic              res_valid;
    logic              out_ready;

    assign s_item    = '{opcode: i_s_tuser, rx_byte: i_s_tdata};
    assign core_fire = core_valid && out_ready;

    afrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .o_valid (core_valid),
        .i_take  (core_fire),
        .o_item  (core_item)
    );

    afrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (core_fire),
        .i_item      (core_item),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    afrc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (out_ready),
        .i_res   (core_res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {7'd0, out_res.byte_index, out_res.frame_byte};
    assign o_m_tlast = out_res.last;
    assign o_m_tuser = out_res.status;

endmodule

`default_nettype wire

[sim/addressed_frame_receiver_crc8_test.sv]
`timescale 1ns / 100ps

module addressed_frame_receiver_crc8_test;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    addressed_frame_receiver_crc8 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register copies
    logic [7:0]  addr_reg;
    logic [15:0] gap_reg;
    logic [15:0] brk_reg;

    // receiver state as predicted
    logic        gap_seen;
    logic        in_frame;
    logic [8:0]  byte_cnt;
    logic [8:0] frame_len;
    logic [7:0]  crc_acc;
    logic [15:0] silence;

    afrc_pkg::t_result due_reports[$];
    int errors = 0;
    int items_sent = 0;
    bit s_calm = 1'b0;
    bit m_calm = 1'b0;
    int m_hold = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) r = r[7] ? ((r << 1) ^ afrc_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic expect_report(input logic [7:0] b, input logic [8:0] idx,
                                 input logic lst, input logic [1:0] st);
        afrc_pkg::t_result r;
        r.frame_byte = b;
        r.byte_index = idx;
        r.last = lst;
        r.status = st;
        due_reports.push_back(r);
    endtask

    task automatic drop_frame();
        in_frame = 1'b0;
        byte_cnt = '0;
        frame_len = '0;
        crc_acc = afrc_pkg::CRC_INIT;
    endtask

    task automatic track_receiver(input logic op, input logic [7:0] b);
        logic [8:0] idx;
        if (op == afrc_pkg::OP_TICK) begin
            if (silence != afrc_pkg::SILENCE_MAX) silence++;
            if (!in_frame) begin
                if (silence >= gap_reg) gap_seen = 1'b1;
            end else if (silence >= brk_reg) begin
                expect_report(8'h00, byte_cnt, 1'b1, afrc_pkg::ST_ABORT);
                drop_frame();
                gap_seen = (silence >= gap_reg);
            end
        end else begin
            silence = '0;
            if (!in_frame) begin
                if (gap_seen && b == addr_reg) begin
                    gap_seen = 1'b0;
                    in_frame = 1'b1;
                    byte_cnt = 9'd1;
                    frame_len = '0;
                    crc_acc = crc_next(afrc_pkg::CRC_INIT, b);
                    expect_report(b, 9'd0, 1'b0, afrc_pkg::ST_BUSY);
                end else if (b != 8'h00) begin
                    gap_seen = 1'b0;
                end
            end else begin
                gap_seen = 1'b0;
                idx = byte_cnt;
                if (idx == 9'd3) frame_len = {1'b0, b} + afrc_pkg::FRAME_OVERHEAD;
                if (idx >= 9'd4 && idx + 9'd1 == frame_len) begin
                    expect_report(b, idx, 1'b1, (b == crc_acc) ? afrc_pkg::ST_CRC_OK :
                                                                 afrc_pkg::ST_CRC_ERR);
                    drop_frame();
                end else begin
                    crc_acc = crc_next(crc_acc, b);
                    byte_cnt = idx + 9'd1;
                    expect_report(b, idx, 1'b0, afrc_pkg::ST_BUSY);
                end
            end
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] b);
        int wait_n;
        logic [7:0] data;
        wait_n = draw_wait(s_calm);
        data = (op == afrc_pkg::OP_TICK) ? 8'($urandom) : b;
        if (wait_n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (wait_n) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_receiver(op, data);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(afrc_pkg::OP_TICK, 8'h00);
    endtask

    // cut >= 0 stops before that byte and lets the line go silent
    task automatic send_frame(input logic [7:0] addr, input int len, input bit bad,
                              input int cut);
        logic [7:0] bytes_q[$];
        logic [7:0] crc;
        bytes_q = {addr, 8'($urandom), 8'($urandom), 8'(len)};
        repeat (len) bytes_q.push_back(8'($urandom));
        crc = afrc_pkg::CRC_INIT;
        foreach (bytes_q[i]) crc = crc_next(crc, bytes_q[i]);
        if (bad) crc ^= 8'($urandom_range(1, 255));
        bytes_q.push_back(crc);
        foreach (bytes_q[i]) begin
            if (i == cut) begin
                send_ticks(brk_reg);
                return;
            end
            if (i > 0 && brk_reg > 1 && $urandom_range(0, 7) == 0) begin
                send_ticks($urandom_range(1, (brk_reg > 4) ? 3 : brk_reg - 1));
            end
            send_item(afrc_pkg::OP_BYTE, bytes_q[i]);
        end
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            afrc_pkg::REG_DEVICE_ADDRESS: addr_reg = val[7:0];
            afrc_pkg::REG_GAP_TICKS:      gap_reg = val;
            afrc_pkg::REG_BREAK_TICKS:    brk_reg = val;
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_ticks(35);
        send_frame(afrc_pkg::ADDR_RESET, 1, 1'b0, -1);
        settle();
    endtask

    task automatic test_directed();
        write_reg(afrc_pkg::REG_DEVICE_ADDRESS, 16'h00A5);
        write_reg(afrc_pkg::REG_GAP_TICKS, 16'd2);
        write_reg(afrc_pkg::REG_BREAK_TICKS, 16'd4);
        // zero byte keeps the gap, then a frame with no data
        send_ticks(2);
        send_item(afrc_pkg::OP_BYTE, 8'h00);
        send_frame(8'hA5, 0, 1'b0, -1);
        // foreign byte cancels the gap, address is ignored
        send_ticks(2);
        send_item(afrc_pkg::OP_BYTE, 8'h5A);
        send_item(afrc_pkg::OP_BYTE, 8'hA5);
        send_ticks(2);
        send_frame(8'hA5, 1, 1'b1, -1);
        // silence aborts, and the abort leaves the gap seen
        send_ticks(2);
        send_frame(8'hA5, 3, 1'b0, 2);
        send_frame(8'hA5, 2, 1'b0, 5);
        settle();
        write_reg(REG_NONE, 16'hFFFF);
        send_ticks(2);
        send_frame(8'hA5, 255, 1'b0, -1);
        settle();
    endtask

    task automatic test_long_silence();
        write_reg(afrc_pkg::REG_DEVICE_ADDRESS, 16'h003C);
        write_reg(afrc_pkg::REG_GAP_TICKS, 16'd30);
        write_reg(afrc_pkg::REG_BREAK_TICKS, 16'd50);
        s_calm = 1'b1;
        send_item(afrc_pkg::OP_BYTE, 8'h81);
        send_ticks(29);
        send_item(afrc_pkg::OP_BYTE, 8'h3C);
        send_ticks(30);
        send_item(afrc_pkg::OP_BYTE, 8'h3C);
        send_item(afrc_pkg::OP_BYTE, 8'h07);
        // abort at the break, then the silence keeps counting
        send_ticks(55);
        send_frame(8'h3C, 2, 1'b0, -1);
        s_calm = 1'b0;
        settle();
    endtask

    task automatic test_random();
        int start;
        int pick;
        int len;
        int cut;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                write_reg(afrc_pkg::REG_DEVICE_ADDRESS, 16'h0000);
                write_reg(afrc_pkg::REG_GAP_TICKS, 16'd1);
                write_reg(afrc_pkg::REG_BREAK_TICKS, 16'd1);
            end else if (phase == 6) begin
                write_reg(afrc_pkg::REG_DEVICE_ADDRESS, 16'h00FF);
                write_reg(afrc_pkg::REG_GAP_TICKS, 16'd1);
                write_reg(afrc_pkg::REG_BREAK_TICKS, 16'hFFFF);
            end else begin
                write_reg(afrc_pkg::REG_DEVICE_ADDRESS, 16'($urandom_range(0, 255)));
                write_reg(afrc_pkg::REG_GAP_TICKS, 16'($urandom_range(1, 6)));
                write_reg(afrc_pkg::REG_BREAK_TICKS, 16'($urandom_range(1, 24)));
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 15) == 0) s_calm = !s_calm;
                if ($urandom_range(0, 15) == 0) m_calm = !m_calm;
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    send_ticks(gap_reg + $urandom_range(0, 2));
                    if ($urandom_range(0, 5) == 0) send_item(afrc_pkg::OP_BYTE, 8'h00);
                end
                if (pick < 70) begin
                    pick = $urandom_range(0, 99);
                    len = (pick < 80) ? $urandom_range(0, 6) :
                          (pick < 98) ? $urandom_range(7, 40) : 255;
                    cut = (brk_reg <= 64 && $urandom_range(0, 9) == 0) ?
                          $urandom_range(1, len + 4) : -1;
                    send_frame(addr_reg, len, $urandom_range(0, 9) == 0, cut);
                end else if (pick < 80) begin
                    send_frame(addr_reg ^ 8'($urandom_range(1, 255)),
                               $urandom_range(0, 4), 1'b0, -1);
                end else if (pick < 90) begin
                    send_frame(addr_reg, $urandom_range(0, 4), 1'b0, -1);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_item(1'($urandom_range(0, 1)), 8'($urandom));
                    end
                end
            end
            settle();
        end
    endtask

    // output side: random stalls and in-order comparison
    always @(posedge i_clk) begin
        afrc_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_reports.size() == 0) begin
                report($sformatf("unexpected transfer byte %0d index %0d",
                                 o_m_tdata[7:0], o_m_tdata[16:8]));
            end else begin
                want = due_reports.pop_front();
                if (o_m_tdata[7:0] !== want.frame_byte)
                    report($sformatf("frame_byte %0d, want %0d",
                                     o_m_tdata[7:0], want.frame_byte));
                if (o_m_tdata[16:8] !== want.byte_index)
                    report($sformatf("byte_index %0d, want %0d",
                                     o_m_tdata[16:8], want.byte_index));
                if (o_m_tlast !== want.last)
                    report($sformatf("last %0b, want %0b", o_m_tlast, want.last));
                if (o_m_tuser !== want.status)
                    report($sformatf("status %0d, want %0d", o_m_tuser, want.status));
            end
            m_hold = draw_wait(m_calm);
        end
        if (m_hold > 0) begin
            i_m_tready <= 1'b0;
            m_hold--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser <= afrc_pkg::OP_BYTE;
        i_s_tdata <= 8'h00;
        i_m_tready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= afrc_pkg::REG_DEVICE_ADDRESS;
        i_cfg_data <= 16'h0000;
        addr_reg = afrc_pkg::ADDR_RESET;
        gap_reg = afrc_pkg::GAP_RESET;
        brk_reg = afrc_pkg::BREAK_RESET;
        gap_seen = 1'b0;
        silence = '0;
        drop_frame();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_long_silence();
        test_random();
        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
